### sv/rfa_pkg.sv
// shared types, widths and constants of the rotary flywheel accelerator
// no dependencies; used by every module of the block by scoped names
package rfa_pkg;

    // fixed-point format of the interval estimate (microseconds)
    localparam int FRAC_BITS = 8;
    localparam int IVAL_W    = 40;
    localparam int TIME_W    = 32;
    localparam int DIR_W     = 2;
    localparam int SPEED_W   = 8;
    localparam int STEP_W    = 18;
    localparam int M_W       = 17;

    // stream and register port widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Q16 coefficients: 0.4125 and 1.2, truncated
    localparam int COEF_Q = 16;
    localparam int COEF_W = 17;
    localparam logic [COEF_W-1:0] COEF_OLD  = COEF_W'(27033);
    localparam logic [COEF_W-1:0] COEF_GROW = COEF_W'(78643);

    // derived widths
    localparam int PROD_W = IVAL_W + COEF_W;
    localparam int SHR_W  = PROD_W - COEF_Q;
    localparam int ELT_W  = TIME_W + FRAC_BITS;
    localparam int SUM_W  = ((ELT_W > IVAL_W) ? ELT_W : IVAL_W) + 1;
    localparam int RATE_W = IVAL_W + 4;
    localparam int NUM_W  = 20 + FRAC_BITS;
    localparam int DEN_W  = IVAL_W + SPEED_W;
    localparam int CNT_W  = $clog2(NUM_W);

    // thresholds in interval format
    localparam logic [IVAL_W-1:0] IVAL_MAX = {IVAL_W{1'b1}};
    localparam logic [IVAL_W-1:0] IVAL_ONE = IVAL_W'(64'd1 << FRAC_BITS);
    localparam logic [IVAL_W-1:0] IVAL_LO  = IVAL_W'(64'd10 << FRAC_BITS);
    localparam logic [IVAL_W-1:0] IVAL_HI  = IVAL_W'(64'd1000000 << FRAC_BITS);
    localparam logic [RATE_W-1:0] RATE_HI  = RATE_W'(64'd1000000 << FRAC_BITS);
    localparam logic [NUM_W-1:0]  DIV_NUM  = NUM_W'(64'd1000000 << FRAC_BITS);
    localparam logic [M_W-1:0]    M_MAX    = M_W'(100000);

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(15);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DIVISOR = CFG_IDX_W'(0);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DEN,
        ST_DIV,
        ST_OUT
    } state_t;

    // what a poll turns out to be
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CLICK,
        KIND_REPEAT
    } kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic upd_en;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scale_go;
    } dp_status_t;

endpackage

### sv/rfa_div.sv
// restoring divider: constant numerator over a registered denominator, one bit a cycle
// depends on rfa_pkg
module rfa_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rfa_pkg::DEN_W-1:0]   den,
    output logic [rfa_pkg::NUM_W-1:0]   quot,
    output logic                        busy,
    output logic                        done
);

    logic [rfa_pkg::DEN_W-1:0] den_reg;
    logic [rfa_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [rfa_pkg::NUM_W-1:0] q_reg, q_next;
    logic [rfa_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [rfa_pkg::NUM_W:0]   trial;
    logic [rfa_pkg::DEN_W-1:0] trial_ext;
    logic [rfa_pkg::DEN_W-1:0] diff;
    logic                      ge;

    always_comb begin
        trial     = {rem_reg, q_reg[rfa_pkg::NUM_W-1]};
        trial_ext = rfa_pkg::DEN_W'(trial);
        ge        = trial_ext >= den_reg;
        diff      = trial_ext - den_reg;
        rem_next  = ge ? diff[rfa_pkg::NUM_W-1:0] : trial[rfa_pkg::NUM_W-1:0];
        q_next    = {q_reg[rfa_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rfa_pkg::CNT_W'(rfa_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= rfa_pkg::DIV_NUM;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quot = q_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### sv/rfa_ctrl.sv
// sequencing state machine: input capture, update steps, division wait, result hand-off
// depends on rfa_pkg
module rfa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  rfa_pkg::dp_status_t  status,
    input  logic                 div_done,
    output rfa_pkg::ctrl_cmd_t   cmd,
    output logic                 div_start
);

    rfa_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            rfa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = rfa_pkg::ST_MUL;
                end
            end
            rfa_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = rfa_pkg::ST_UPD;
            end
            rfa_pkg::ST_UPD: begin
                cmd.upd_en = 1'b1;
                state_next = rfa_pkg::ST_DEN;
            end
            rfa_pkg::ST_DEN: begin
                if (status.scale_go) begin
                    div_start  = 1'b1;
                    state_next = rfa_pkg::ST_DIV;
                end else begin
                    state_next = rfa_pkg::ST_OUT;
                end
            end
            rfa_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rfa_pkg::ST_OUT;
                end
            end
            rfa_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = rfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

### sv/rfa_dp.sv
// datapath: timing state, interval smoothing and growth, denominator, step encoding
// depends on rfa_pkg
module rfa_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rfa_pkg::ctrl_cmd_t             cmd,
    input  logic [rfa_pkg::DIR_W-1:0]      detent,
    input  logic [rfa_pkg::TIME_W-1:0]     now_us,
    input  logic [rfa_pkg::SPEED_W-1:0]    speed_divisor,
    input  logic [rfa_pkg::NUM_W-1:0]      div_quot,
    output logic [rfa_pkg::DEN_W-1:0]      den,
    output rfa_pkg::dp_status_t            status,
    output logic [rfa_pkg::STEP_W-1:0]     step
);

    // block state, cleared by reset
    logic [rfa_pkg::TIME_W-1:0] last_event_reg;
    logic [rfa_pkg::IVAL_W-1:0] interval_reg;
    logic [rfa_pkg::DIR_W-1:0]  last_dir_reg;

    // per-poll working registers
    logic [rfa_pkg::DIR_W-1:0]  dir_reg;
    logic [rfa_pkg::TIME_W-1:0] now_reg;
    logic [rfa_pkg::TIME_W-1:0] elapsed_reg;
    logic [rfa_pkg::PROD_W-1:0] prod_old_reg;
    logic [rfa_pkg::PROD_W-1:0] prod_grow_reg;
    rfa_pkg::kind_t             kind_reg;
    logic [rfa_pkg::IVAL_W-1:0] scale_ival_reg;
    logic                       scale_go_reg;
    logic [rfa_pkg::DIR_W-1:0]  out_dir_reg;
    logic [rfa_pkg::STEP_W-1:0] step_reg;

    logic [rfa_pkg::DIR_W-1:0]  dir_in;
    logic [rfa_pkg::SUM_W-1:0]  elapsed_fx;
    logic [rfa_pkg::RATE_W-1:0] ival15;
    logic                       repeat_ok;
    rfa_pkg::kind_t             kind_in;
    logic [rfa_pkg::TIME_W+3:0] e11;
    logic [rfa_pkg::SUM_W-1:0]  ival_sum;
    logic [rfa_pkg::IVAL_W-1:0] ival_click;
    logic [rfa_pkg::SHR_W-1:0]  grown;
    logic [rfa_pkg::IVAL_W-1:0] ival_grown;
    logic [rfa_pkg::M_W-1:0]    m_sat;
    logic [rfa_pkg::STEP_W-1:0] m_ext;
    logic [rfa_pkg::STEP_W-1:0] step_calc;

    // detent code 2'b10 counts as ccw
    always_comb begin
        case (detent)
            2'b00:   dir_in = 2'b00;
            2'b01:   dir_in = 2'b01;
            default: dir_in = 2'b11;
        endcase
    end

    // repeat test on the captured elapsed time and the stored interval
    always_comb begin
        elapsed_fx = rfa_pkg::SUM_W'(elapsed_reg) << rfa_pkg::FRAC_BITS;
        ival15     = (rfa_pkg::RATE_W'(interval_reg) << 4) - rfa_pkg::RATE_W'(interval_reg);
        repeat_ok  = (elapsed_fx > rfa_pkg::SUM_W'(interval_reg)) &&
                     (interval_reg >= rfa_pkg::IVAL_ONE) &&
                     (ival15 < rfa_pkg::RATE_HI);
        if (dir_reg != 2'b00) begin
            kind_in = rfa_pkg::KIND_CLICK;
        end else if (repeat_ok) begin
            kind_in = rfa_pkg::KIND_REPEAT;
        end else begin
            kind_in = rfa_pkg::KIND_NONE;
        end
    end

    // smoothed and grown intervals, both saturating
    always_comb begin
        e11 = {4'b0, elapsed_reg} << 3;
        e11 = e11 + ({4'b0, elapsed_reg} << 1) + {4'b0, elapsed_reg};
        ival_sum = rfa_pkg::SUM_W'(prod_old_reg[rfa_pkg::PROD_W-1:rfa_pkg::COEF_Q]) +
                   (rfa_pkg::SUM_W'(e11) << (rfa_pkg::FRAC_BITS - 4));
        ival_click = (ival_sum > rfa_pkg::SUM_W'(rfa_pkg::IVAL_MAX)) ?
                     rfa_pkg::IVAL_MAX : ival_sum[rfa_pkg::IVAL_W-1:0];
        grown      = prod_grow_reg[rfa_pkg::PROD_W-1:rfa_pkg::COEF_Q];
        ival_grown = (grown > rfa_pkg::SHR_W'(rfa_pkg::IVAL_MAX)) ?
                     rfa_pkg::IVAL_MAX : grown[rfa_pkg::IVAL_W-1:0];
    end

    // step from direction and saturated multiplier; a zero multiplier gives the direction
    always_comb begin
        if (!scale_go_reg) begin
            m_sat = '0;
        end else if (div_quot > rfa_pkg::NUM_W'(rfa_pkg::M_MAX)) begin
            m_sat = rfa_pkg::M_MAX;
        end else begin
            m_sat = div_quot[rfa_pkg::M_W-1:0];
        end
        m_ext = rfa_pkg::STEP_W'(m_sat);
        if (out_dir_reg == 2'b00) begin
            step_calc = '0;
        end else if (m_sat == '0) begin
            step_calc = {{(rfa_pkg::STEP_W-rfa_pkg::DIR_W){out_dir_reg[1]}}, out_dir_reg};
        end else if (out_dir_reg[1]) begin
            step_calc = -m_ext;
        end else begin
            step_calc = m_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_event_reg <= '0;
            interval_reg   <= '0;
            last_dir_reg   <= '0;
        end else if (cmd.upd_en) begin
            case (kind_reg)
                rfa_pkg::KIND_CLICK: begin
                    interval_reg   <= ival_click;
                    last_event_reg <= now_reg;
                    last_dir_reg   <= dir_reg;
                end
                rfa_pkg::KIND_REPEAT: begin
                    interval_reg   <= ival_grown;
                    last_event_reg <= now_reg;
                end
                default: begin
                    interval_reg <= interval_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dir_reg     <= dir_in;
            now_reg     <= now_us;
            elapsed_reg <= now_us - last_event_reg;
        end
        if (cmd.mul_en) begin
            prod_old_reg  <= rfa_pkg::PROD_W'(interval_reg) * rfa_pkg::PROD_W'(rfa_pkg::COEF_OLD);
            prod_grow_reg <= rfa_pkg::PROD_W'(interval_reg) * rfa_pkg::PROD_W'(rfa_pkg::COEF_GROW);
            kind_reg      <= kind_in;
        end
        if (cmd.upd_en) begin
            case (kind_reg)
                rfa_pkg::KIND_CLICK: begin
                    scale_ival_reg <= ival_click;
                    scale_go_reg   <= (ival_click > rfa_pkg::IVAL_LO) &&
                                      (ival_click < rfa_pkg::IVAL_HI) &&
                                      (speed_divisor != '0);
                    out_dir_reg    <= dir_reg;
                end
                rfa_pkg::KIND_REPEAT: begin
                    scale_ival_reg <= interval_reg;
                    scale_go_reg   <= speed_divisor != '0;
                    out_dir_reg    <= last_dir_reg;
                end
                default: begin
                    scale_ival_reg <= interval_reg;
                    scale_go_reg   <= 1'b0;
                    out_dir_reg    <= '0;
                end
            endcase
        end
        if (cmd.load_out) begin
            step_reg <= step_calc;
        end
    end

    assign den             = rfa_pkg::DEN_W'(scale_ival_reg) * rfa_pkg::DEN_W'(speed_divisor);
    assign status.scale_go = scale_go_reg;
    assign step            = step_reg;

endmodule

### sv/rotary_flywheel_accelerator_unit.sv
// rotary flywheel accelerator: one step result per poll, scaled by click rate
// accepted poll: ST_MUL, ST_UPD, ST_DEN, ST_DIV if the rate multiplier is divided out, ST_OUT
// one poll in flight, next accepted back in ST_IDLE; division runs on the 28-bit serial divider
// synchronous active-low reset clears timing state, interval, direction, handshakes;
// speed_divisor returns to 15
// depends on rfa_pkg, rfa_ctrl, rfa_dp, rfa_div
module rotary_flywheel_accelerator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input polls
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rfa_pkg::IN_TDATA_W-1:0]    s_tdata,   // [1:0] detent, [33:2] now_us

    // step results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rfa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [17:0] step

    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfa_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rfa_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rfa_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [rfa_pkg::SPEED_W-1:0]   speed_divisor_reg;
    logic [rfa_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic                          cfg_write;

    rfa_pkg::ctrl_cmd_t            cmd;
    rfa_pkg::dp_status_t           status;
    logic                          div_start;
    logic                          div_busy;
    logic                          div_done;
    logic [rfa_pkg::DEN_W-1:0]     den;
    logic [rfa_pkg::NUM_W-1:0]     div_quot;
    logic [rfa_pkg::STEP_W-1:0]    step;

    // register file: speed_divisor at byte addresses 0 to 3, writes with paddr[2] set are dropped
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[rfa_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_divisor_reg <= rfa_pkg::SPEED_RESET;
        end else if (cfg_write && (cfg_idx == rfa_pkg::REG_SPEED_DIVISOR)) begin
            speed_divisor_reg <= pwdata[rfa_pkg::SPEED_W-1:0];
        end
    end

    // reads of unmapped addresses return zero
    always_comb begin
        if (cfg_idx == rfa_pkg::REG_SPEED_DIVISOR) begin
            prdata = rfa_pkg::CFG_DATA_W'(speed_divisor_reg);
        end else begin
            prdata = '0;
        end
    end

    // sequencer: one poll in flight, output register lets the next poll in while a step waits
    rfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .div_done  (div_done),
        .cmd       (cmd),
        .div_start (div_start)
    );

    // interval arithmetic and step encoding
    rfa_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .detent        (s_tdata[1:0]),
        .now_us        (s_tdata[rfa_pkg::TIME_W+1:2]),
        .speed_divisor (speed_divisor_reg),
        .div_quot      (div_quot),
        .den           (den),
        .status        (status),
        .step          (step)
    );

    // rate multiplier: 1e6 in interval format over interval times speed_divisor
    rfa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (den),
        .quot    (div_quot),
        .busy    (div_busy),
        .done    (div_done)
    );

    assign m_tdata = rfa_pkg::OUT_TDATA_W'(step);

    // a poll is held alone: no second transaction right after acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // the divider only runs while a poll is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_tready)
        else $error("divider busy while the sequencer is idle");

    // step magnitude stays within the multiplier limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(step) <= $signed(rfa_pkg::STEP_W'(rfa_pkg::M_MAX))) &&
                      ($signed(step) >= -$signed(rfa_pkg::STEP_W'(rfa_pkg::M_MAX)))))
        else $error("step magnitude above saturation limit");

endmodule

### bench/rfa_step_checker.sv
`timescale 1ns / 1ps
// step checker for the rotary flywheel accelerator: tracks timing, interval and direction
// per poll transaction, queues the expected step, compares every result transaction and checks
// speed_divisor readbacks; depends on rfa_pkg; instantiated beside the block by tb_top
module rfa_step_checker
    import rfa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [1:0] detent, [33:2] now_us
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [17:0] step
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic [CFG_DATA_W-1:0]  prdata,
    input  logic                   pready,
    output int                     outstanding,
    output int                     errors
);

    logic [TIME_W-1:0]        last_evt_us;
    logic [IVAL_W-1:0]        ival_est;
    logic signed [DIR_W-1:0]  coast_dir;
    logic [SPEED_W-1:0]       speed_div;
    logic [STEP_W-1:0]        step_q[$];
    int                       pending_cnt = 0;
    int                       fail_count = 0;

    assign outstanding = pending_cnt;
    assign errors      = fail_count;

    function automatic logic [63:0] rate_mult(input logic [IVAL_W-1:0] iv);
        logic [63:0] den;
        logic [63:0] m;
        if (speed_div == '0)
            return 64'd1;
        den = 64'(iv) * 64'(speed_div);
        if (den == 64'd0)
            return 64'd0;
        m = (64'd1000000 << FRAC_BITS) / den;
        return (m > 64'(M_MAX)) ? 64'(M_MAX) : m;
    endfunction

    function automatic logic [STEP_W-1:0] scaled_step(input int dir, input logic [63:0] m);
        longint v;
        v = dir;
        if (m != 64'd0)
            v = v * longint'(m);
        return v[STEP_W-1:0];
    endfunction

    // one poll: classify, update the flywheel state, return the step it produces
    function automatic logic [STEP_W-1:0] advance_flywheel(input logic [DIR_W-1:0] det,
                                                           input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       acc;
        logic [63:0]       m;
        int                dir;
        kind_t             kind;
        elapsed = now - last_evt_us;
        dir = (det == 2'b00) ? 0 : ((det == 2'b01) ? 1 : -1);
        if (dir != 0)
            kind = KIND_CLICK;
        else if ((64'(elapsed) << FRAC_BITS) > 64'(ival_est) && ival_est >= IVAL_ONE &&
                 64'(ival_est) * 64'd15 < (64'd1000000 << FRAC_BITS))
            kind = KIND_REPEAT;
        else
            kind = KIND_NONE;
        case (kind)
            KIND_CLICK: begin
                acc = ((64'(ival_est) * 64'(COEF_OLD)) >> COEF_Q) +
                      ((64'(elapsed) * 64'd11) << (FRAC_BITS - 4));
                ival_est = (acc > 64'(IVAL_MAX)) ? IVAL_MAX : acc[IVAL_W-1:0];
                coast_dir = DIR_W'(dir);
                last_evt_us = now;
                m = (ival_est > IVAL_LO && ival_est < IVAL_HI && speed_div != '0) ?
                    rate_mult(ival_est) : 64'd0;
                return scaled_step(dir, m);
            end
            KIND_REPEAT: begin
                m = rate_mult(ival_est);
                acc = (64'(ival_est) * 64'(COEF_GROW)) >> COEF_Q;
                ival_est = (acc > 64'(IVAL_MAX)) ? IVAL_MAX : acc[IVAL_W-1:0];
                last_evt_us = now;
                return scaled_step(int'(coast_dir), m);
            end
            default: return '0;
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [STEP_W-1:0] want;
        if (!aresetn) begin
            last_evt_us = '0;
            ival_est    = '0;
            coast_dir   = '0;
            speed_div   = SPEED_RESET;
            step_q.delete();
        end else begin
            if (psel && penable && pready &&
                paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_SPEED_DIVISOR)) begin
                if (pwrite) begin
                    speed_div = pwdata[SPEED_W-1:0];
                end else if (prdata[SPEED_W-1:0] !== speed_div) begin
                    $error("speed_divisor mismatch: expected %0d actual %0d",
                           speed_div, prdata[SPEED_W-1:0]);
                    fail_count = fail_count + 1;
                end
            end
            // results are retired before the new poll is queued
            if (m_tvalid && m_tready) begin
                if (step_q.size() == 0) begin
                    $error("step mismatch: expected none actual %0d",
                           $signed(m_tdata[STEP_W-1:0]));
                    fail_count = fail_count + 1;
                end else begin
                    want = step_q.pop_front();
                    if (m_tdata[STEP_W-1:0] !== want) begin
                        $error("step mismatch: expected %0d actual %0d",
                               $signed(want), $signed(m_tdata[STEP_W-1:0]));
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                step_q.push_back(advance_flywheel(s_tdata[DIR_W-1:0],
                                                  s_tdata[DIR_W+TIME_W-1:DIR_W]));
        end
        pending_cnt <= step_q.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// top of the rotary flywheel accelerator bench: clock, reset, poll and register stimulus,
// result back-pressure and the verdict; depends on rfa_pkg, the block and rfa_step_checker
module tb_top;
    import rfa_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [CFG_ADDR_W-1:0] SPEED_ADDR = {REG_SPEED_DIVISOR, 2'b00};

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [1:0] detent, [33:2] now_us
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [17:0] step
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     outstanding;
    int                     errors;
    int                     n_sent = 0;
    int                     cycle_cnt = 0;
    logic [TIME_W-1:0]      clk_us;
    logic                   quiet;

    // stretch of polls where neither side idles
    assign quiet = (n_sent >= 700 && n_sent < 1000);

    rotary_flywheel_accelerator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rfa_step_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit: a hung handshake ends here
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while polls keep coming
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (!hold_done && n_sent >= 320) begin
                // block fills up and must stall its poll input
                hold_done = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 15);
            end
        end
    end

    // one poll transaction, with random idle cycles ahead of it
    task automatic poll(input logic [DIR_W-1:0] det, input logic [TIME_W-1:0] stamp);
        while (!quiet && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({stamp, det});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent = n_sent + 1;
    endtask

    // stop offering polls until every expected step has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // optional speed_divisor write, always followed by a readback
    task automatic speed_cycle(input bit wr, input logic [SPEED_W-1:0] val);
        if (wr) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= SPEED_ADDR;
            pwdata  <= CFG_DATA_W'(val);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SPEED_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [SPEED_W-1:0] phase_speed[8];
        logic [DIR_W-1:0]   det;
        int unsigned        gap;
        int unsigned        r;
        int                 target;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        clk_us   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of speed_divisor read back before any write
        speed_cycle(1'b0, '0);

        // idle from reset, click below 10 us, scaled repeat, ccw as pattern -2
        poll(2'b00, 32'd0);
        poll(2'b01, 32'd3);
        poll(2'b00, 32'd6);
        poll(2'b10, 32'd8);
        drain();

        // divisor 1 with a tiny interval: repeat multiplier saturates
        speed_cycle(1'b1, 8'd1);
        poll(2'b00, 32'd11);
        poll(2'b00, 32'd12);
        poll(2'b01, 32'd14);
        drain();

        // millisecond clicks then coasting, some polls too early to repeat
        speed_cycle(1'b1, 8'd15);
        poll(2'b01, 32'd1000);
        poll(2'b01, 32'd2000);
        poll(2'b11, 32'd3000);
        poll(2'b00, 32'd3100);
        poll(2'b00, 32'd5000);
        poll(2'b00, 32'd8000);
        poll(2'b00, 32'd20000);
        poll(2'b00, 32'd60000);
        drain();

        // scaling disabled: click and repeat give the bare direction
        speed_cycle(1'b1, 8'd0);
        poll(2'b01, 32'd61000);
        poll(2'b00, 32'd120000);
        drain();

        // largest divisor, then elapsed of 2^32-1 three times: timestamp wrap and
        // interval saturation, followed by a poll that must stay idle
        speed_cycle(1'b1, 8'd255);
        poll(2'b11, 32'd120500);
        poll(2'b01, 32'd121000);
        poll(2'b01, 32'd120999);
        poll(2'b01, 32'd120998);
        poll(2'b01, 32'd120997);
        poll(2'b00, 32'd121100);
        clk_us = 32'd121100;
        drain();

        // random part: eight phases, each with its own divisor
        phase_speed = '{8'd15, 8'd0, 8'd255, 8'd1, 8'd2,
                        SPEED_W'($urandom_range(255)), SPEED_W'($urandom_range(255)), 8'd40};
        for (int p = 0; p < 8; p++) begin
            speed_cycle(1'b1, phase_speed[p]);
            target = n_sent + 210;
            while (n_sent < target) begin
                if ($urandom_range(99) < 75) begin
                    // well-formed gesture: a run of clicks at one pace, then coasting polls
                    r = $urandom_range(99);
                    if (r < 25)
                        gap = $urandom_range(40, 1);
                    else if (r < 65)
                        gap = $urandom_range(20000, 40);
                    else if (r < 90)
                        gap = $urandom_range(300000, 20000);
                    else
                        gap = $urandom_range(3000000, 300000);
                    det = ($urandom_range(99) < 50) ? 2'b01 : 2'b11;
                    repeat ($urandom_range(12, 1)) begin
                        if ($urandom_range(99) < 8)
                            det = DIR_W'($urandom_range(3, 1));
                        clk_us = clk_us + gap + $urandom_range(gap / 4);
                        poll(det, clk_us);
                    end
                    repeat ($urandom_range(12, 0)) begin
                        clk_us = clk_us + $urandom_range(2 * gap + 1, 1);
                        poll(2'b00, clk_us);
                    end
                end else begin
                    // noise: any detent pattern, timestamps anywhere or close by
                    repeat ($urandom_range(6, 1)) begin
                        if ($urandom_range(1) == 1)
                            clk_us = $urandom;
                        else
                            clk_us = clk_us + $urandom_range(500);
                        poll(DIR_W'($urandom_range(3)), clk_us);
                    end
                end
            end
            drain();
        end

        // let any late or extra transaction show up before the verdict
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
